// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the double-ended queue: capacity, widths, operation and
// status codes, and the beat types of the input and result channels.
// No dependencies.
package deq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int OCC_W    = 7;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [OCC_W-1:0]         occupancy;
    logic [STATUS_W-1:0]      status;
  } out_item_t;

endpackage

// ===== rtl/deq_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port slot memory: one write port, one read port with
// registered read data. No package dependency.
module deq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit values in a circular slot
// memory. Every beat accepted on start gives one result on out_valid in the
// following cycle; the block takes one beat per clock, and busy is high only
// during reset and in the first cycle after it. The rate is set by the slot
// memory's single read port: a pop from three or more entries reads the new
// end slot, and that read data is forwarded straight into the next operation.
// Depends on deq_pkg and deq_ram.
module double_ended_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::in_item_t  in_data,
  output logic               out_valid,
  output deq_pkg::out_item_t out_data
);

  import deq_pkg::*;

  logic                     busy_r;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         front_idx_r, front_idx_nxt;
  logic [IDX_W-1:0]         rear_idx_r, rear_idx_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [DATA_W-1:0] front_val_r, front_val_nxt;
  logic signed [DATA_W-1:0] rear_val_r, rear_val_nxt;
  logic                     front_mem_r, front_mem_nxt;
  logic                     rear_mem_r, rear_mem_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;

  logic                     acc;
  logic                     q_empty, q_full;
  logic signed [DATA_W-1:0] front_cur, rear_cur;
  logic [IDX_W-1:0]         front_inc, front_dec, rear_inc, rear_dec;
  logic                     we, re;
  logic [IDX_W-1:0]         waddr, raddr;
  logic [DATA_W-1:0]        rdata;

  assign acc     = start && !busy_r;
  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == CNT_W'(CAPACITY));

  // forward pending memory reads into the current end values
  assign front_cur = front_mem_r ? $signed(rdata) : front_val_r;
  assign rear_cur  = rear_mem_r ? $signed(rdata) : rear_val_r;

  assign front_inc = (front_idx_r == IDX_W'(CAPACITY - 1)) ? '0 : front_idx_r + 1'b1;
  assign front_dec = (front_idx_r == '0) ? IDX_W'(CAPACITY - 1) : front_idx_r - 1'b1;
  assign rear_inc  = (rear_idx_r == IDX_W'(CAPACITY - 1)) ? '0 : rear_idx_r + 1'b1;
  assign rear_dec  = (rear_idx_r == '0) ? IDX_W'(CAPACITY - 1) : rear_idx_r - 1'b1;

  always_comb begin
    front_idx_nxt = front_idx_r;
    rear_idx_nxt  = rear_idx_r;
    count_nxt     = count_r;
    front_val_nxt = front_cur;
    rear_val_nxt  = rear_cur;
    front_mem_nxt = 1'b0;
    rear_mem_nxt  = 1'b0;
    status_nxt    = STATUS_DONE;
    we            = 1'b0;
    waddr         = front_idx_r;
    re            = 1'b0;
    raddr         = front_inc;
    if (acc) begin
      unique case (in_data.kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (q_full) begin
            status_nxt = STATUS_OVERFLOW;
          end else if (q_empty) begin
            we            = 1'b1;
            waddr         = front_idx_r;
            rear_idx_nxt  = front_idx_r;
            count_nxt     = CNT_W'(1);
            front_val_nxt = in_data.push_value;
            rear_val_nxt  = in_data.push_value;
          end else if (in_data.kind == KIND_PUSH_FRONT) begin
            we            = 1'b1;
            waddr         = front_dec;
            front_idx_nxt = front_dec;
            count_nxt     = count_r + 1'b1;
            front_val_nxt = in_data.push_value;
          end else begin
            we           = 1'b1;
            waddr        = rear_inc;
            rear_idx_nxt = rear_inc;
            count_nxt    = count_r + 1'b1;
            rear_val_nxt = in_data.push_value;
          end
        end
        KIND_POP_FRONT: begin
          if (q_empty) begin
            status_nxt = STATUS_UNDERFLOW;
          end else begin
            count_nxt = count_r - 1'b1;
            if (count_r == CNT_W'(2)) begin
              front_idx_nxt = front_inc;
              front_val_nxt = rear_cur;
            end else if (count_r != CNT_W'(1)) begin
              front_idx_nxt = front_inc;
              re            = 1'b1;
              raddr         = front_inc;
              front_mem_nxt = 1'b1;
            end
          end
        end
        KIND_POP_BACK: begin
          if (q_empty) begin
            status_nxt = STATUS_UNDERFLOW;
          end else begin
            count_nxt = count_r - 1'b1;
            if (count_r == CNT_W'(2)) begin
              rear_idx_nxt = rear_dec;
              rear_val_nxt = front_cur;
            end else if (count_r != CNT_W'(1)) begin
              rear_idx_nxt = rear_dec;
              re           = 1'b1;
              raddr        = rear_dec;
              rear_mem_nxt = 1'b1;
            end
          end
        end
        default: begin
          status_nxt = STATUS_DONE;
        end
      endcase
    end
  end

  deq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_data.push_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      front_idx_r <= '0;
      rear_idx_r  <= '0;
      count_r     <= '0;
      front_mem_r <= 1'b0;
      rear_mem_r  <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= acc;
      if (acc) begin
        front_idx_r <= front_idx_nxt;
        rear_idx_r  <= rear_idx_nxt;
        count_r     <= count_nxt;
        front_mem_r <= front_mem_nxt;
        rear_mem_r  <= rear_mem_nxt;
      end
    end
  end

  // hold end values and status between beats
  always_ff @(posedge clk) begin
    if (acc) begin
      front_val_r <= front_val_nxt;
      rear_val_r  <= rear_val_nxt;
      status_r    <= status_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  always_comb begin
    out_data.front_value = q_empty ? EMPTY_MARK : front_cur;
    out_data.rear_value  = q_empty ? EMPTY_MARK : rear_cur;
    out_data.is_empty    = q_empty;
    out_data.is_full     = q_full;
    out_data.occupancy   = OCC_W'(count_r);
    out_data.status      = status_r;
  end

`ifndef SYNTHESIS
  a_result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted beat gave no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> !out_valid)
    else $error("result without accepted beat");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STATUS_OVERFLOW) |-> out_data.is_full)
    else $error("overflow reported on a queue that is not full");

  a_single_mem_forward: assert property (@(posedge clk) disable iff (!rst_n)
    !(front_mem_r && rear_mem_r))
    else $error("both ends forwarded from one read");
`endif

endmodule

// ===== tb/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: a scoreboard class that tracks
// the deque contents and predicts every result beat, plus tasks that drive it.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 1630;

  class deque_scoreboard;
    logic signed [DATA_W-1:0] slot_mem [CAPACITY];
    int front_idx;
    int rear_idx;
    int entries;
    out_item_t pending_results[$];
    int mismatches;
    int checked;
    int pushes;
    int pops;
    int overflows;
    int underflows;

    function new();
      front_idx  = 0;
      rear_idx   = 0;
      entries    = 0;
      mismatches = 0;
      checked    = 0;
      pushes     = 0;
      pops       = 0;
      overflows  = 0;
      underflows = 0;
    endfunction

    // Apply one accepted operation to the shadow deque and queue its result.
    function void note_op(in_item_t op);
      out_item_t res;
      logic [STATUS_W-1:0] st;
      st = STATUS_DONE;
      if (op.kind == KIND_PUSH_FRONT || op.kind == KIND_PUSH_BACK) begin
        pushes++;
        if (entries >= CAPACITY) begin
          st = STATUS_OVERFLOW;
          overflows++;
        end else if (entries == 0) begin
          slot_mem[front_idx] = op.push_value;
          rear_idx = front_idx;
          entries = 1;
        end else if (op.kind == KIND_PUSH_FRONT) begin
          front_idx = (front_idx == 0) ? CAPACITY - 1 : front_idx - 1;
          slot_mem[front_idx] = op.push_value;
          entries++;
        end else begin
          rear_idx = (rear_idx == CAPACITY - 1) ? 0 : rear_idx + 1;
          slot_mem[rear_idx] = op.push_value;
          entries++;
        end
      end else begin
        pops++;
        if (entries == 0) begin
          st = STATUS_UNDERFLOW;
          underflows++;
        end else begin
          // last entry: indices stay put
          if (entries > 1) begin
            if (op.kind == KIND_POP_FRONT)
              front_idx = (front_idx == CAPACITY - 1) ? 0 : front_idx + 1;
            else
              rear_idx = (rear_idx == 0) ? CAPACITY - 1 : rear_idx - 1;
          end
          entries--;
        end
      end
      res.front_value = (entries == 0) ? EMPTY_MARK : slot_mem[front_idx];
      res.rear_value  = (entries == 0) ? EMPTY_MARK : slot_mem[rear_idx];
      res.is_empty    = (entries == 0);
      res.is_full     = (entries >= CAPACITY);
      res.occupancy   = entries[OCC_W-1:0];
      res.status      = st;
      pending_results.push_back(res);
    endfunction

    function void check_beat(out_item_t got);
      out_item_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: %p", got);
        mismatches++;
        return;
      end
      exp_res = pending_results.pop_front();
      checked++;
      if (got.front_value !== exp_res.front_value) begin
        $error("front_value: expected %0d, got %0d", exp_res.front_value, got.front_value);
        mismatches++;
      end
      if (got.rear_value !== exp_res.rear_value) begin
        $error("rear_value: expected %0d, got %0d", exp_res.rear_value, got.rear_value);
        mismatches++;
      end
      if (got.is_empty !== exp_res.is_empty) begin
        $error("is_empty: expected %0b, got %0b", exp_res.is_empty, got.is_empty);
        mismatches++;
      end
      if (got.is_full !== exp_res.is_full) begin
        $error("is_full: expected %0b, got %0b", exp_res.is_full, got.is_full);
        mismatches++;
      end
      if (got.occupancy !== exp_res.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp_res.occupancy, got.occupancy);
        mismatches++;
      end
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  deque_scoreboard sb;
  int cycles;
  int idle_pct;

  double_ended_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_beat(out_data);
  end

  // Drive one operation beat, with a random idle gap ahead of it.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 12)
      gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data.kind <= kind;
    in_data.push_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_op('{kind: kind, push_value: val});
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(11))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int n_ops, input int pct);
    bit filling;
    int k;
    logic [KIND_W-1:0] kind;
    filling = 1'b1;
    for (k = 0; k < n_ops; k++) begin
      if (filling && sb.entries >= CAPACITY && $urandom_range(3) == 0)
        filling = 1'b0;
      else if (!filling && sb.entries == 0 && $urandom_range(3) == 0)
        filling = 1'b1;
      else if ($urandom_range(39) == 0)
        filling = !filling;
      if ($urandom_range(9) == 0)
        kind = KIND_W'($urandom_range(3));
      else if (($urandom_range(99) < 80) == filling)
        kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      else
        kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
      // stretches with no idling inside idle phases
      idle_pct = (k % 100 < 20) ? 0 : pct;
      send_op(kind, pick_value());
    end
  endtask

  initial begin
    sb       = new();
    cycles   = 0;
    idle_pct = 0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: underflow on both ends, push onto empty, extremes, last-entry pop.
    send_op(KIND_POP_FRONT, 32'sd5);
    send_op(KIND_POP_BACK, -32'sd5);
    send_op(KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_op(KIND_POP_BACK, 32'sd0);
    send_op(KIND_PUSH_BACK, 32'sh8000_0000);
    send_op(KIND_POP_FRONT, 32'sd0);
    send_op(KIND_POP_FRONT, 32'sd0);
    send_op(KIND_PUSH_BACK, -32'sd1);
    send_op(KIND_PUSH_FRONT, 32'sd0);
    send_op(KIND_PUSH_BACK, 32'sh5555_5555);
    send_op(KIND_PUSH_FRONT, 32'shAAAA_AAAA);
    send_op(KIND_POP_BACK, 32'sd1);
    send_op(KIND_POP_FRONT, 32'sd1);
    send_op(KIND_PUSH_BACK, 32'sh7FFF_FFFF);
    send_op(KIND_POP_BACK, 32'sd0);
    send_op(KIND_POP_BACK, 32'sd0);
    send_op(KIND_POP_FRONT, 32'sd0);
    send_op(KIND_POP_BACK, 32'sd0);
    send_op(KIND_PUSH_FRONT, 32'sh8000_0000);
    send_op(KIND_POP_FRONT, 32'sd0);

    // Random phases: no idling, heavy sender idling, none, moderate idling.
    for (int p = 0; p < 4; p++) begin
      run_random(N_RANDOM / 4, (p == 1) ? 62 : (p == 3) ? 38 : 0);
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d operations (%0d pushes, %0d pops), %0d results checked",
             sb.pushes + sb.pops, sb.pushes, sb.pops, sb.checked);
    $display("%0d overflow and %0d underflow cases, %0d mismatches",
             sb.overflows, sb.underflows, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
